/* hdl/mpp_pkg.sv */
// ----------------------------------------------------------------------------
// mpp_pkg
// Shared widths, constants and the divider control bundle for the motor
// position PID controller.
// ----------------------------------------------------------------------------
package mpp_pkg;

    // encoder count width of the position inputs
    localparam int POSITION_WIDTH = 32;

    // shared divider: dividend/quotient width, divisor width, step counter
    localparam int DIV_W  = 96;
    localparam int DEN_W  = 20;
    localparam int STEP_W = 6;

    // rate numerator magnitude: |(e - e_prev) * 1e6| < 2^53, kept even for radix 4
    localparam int RATE_MAG_W = 54;

    // two quotient bits per divider step
    localparam logic [STEP_W-1:0] RATE_STEPS = STEP_W'(RATE_MAG_W / 2);
    localparam logic [STEP_W-1:0] INT_STEPS  = STEP_W'(DIV_W / 2);

    localparam logic [DEN_W-1:0] MICROS_PER_SEC = DEN_W'(1000000);

    // one request to the shared divider
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
        logic [DIV_W-1:0]  dividend;
        logic [DEN_W-1:0]  divisor;
    } t_div_ctl;

endpackage

/* hdl/mpp_div.sv */
// ----------------------------------------------------------------------------
// mpp_div
// Iterative unsigned restoring divider, two quotient bits per cycle. The
// dividend is left aligned; after the requested number of steps the low
// bits of the shift register hold the quotient.
// ----------------------------------------------------------------------------
module mpp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mpp_pkg::t_div_ctl          i_ctl,
    output logic                       o_done,
    output logic [mpp_pkg::DIV_W-1:0]  o_quot
);
    import mpp_pkg::*;

    logic [DIV_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    w_t1, w_r1, w_t2, w_r2;
    logic              w_ge1, w_ge2;

    // two chained compare/subtract steps
    always_comb begin
        w_t1  = {r_rem, r_num[DIV_W-1]};
        w_ge1 = (w_t1 >= {1'b0, r_den});
        w_r1  = w_ge1 ? (w_t1 - {1'b0, r_den}) : w_t1;
        w_t2  = {w_r1[DEN_W-1:0], r_num[DIV_W-2]};
        w_ge2 = (w_t2 >= {1'b0, r_den});
        w_r2  = w_ge2 ? (w_t2 - {1'b0, r_den}) : w_t2;
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_num <= i_ctl.dividend;
            r_rem <= '0;
            r_den <= i_ctl.divisor;
        end else if (r_busy) begin
            r_num <= {r_num[DIV_W-3:0], w_ge1, w_ge2};
            r_rem <= w_r2[DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

/* hdl/motor_position_pid.sv */
// ----------------------------------------------------------------------------
// motor_position_pid
// PID position controller for one motor bridge: error, rate and integral
// combined with three Q8.24 gains; |u| clamped to the duty limit, sign on
// the two bridge levels.
// ----------------------------------------------------------------------------
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  input     | i_in_valid / o_in_stall, position fields  | in
//  result    | o_out_valid / i_out_stall, duty, pins     | out
//  config    | i_cfg_wr_en, i_cfg_index, i_cfg_data      | in
//
//  The shared radix-4 divider runs 27 steps for the rate and 48 steps for
//  the integral term over one million; the shared 33x33 multiplier and
//  the sequencer states, from the idle state that takes the transfer on,
//  compute the rest of each item.
//  Synchronous active-low reset clears the gains, sets duty limit to 50 and
//  zeroes the previous error and the integral.
//  One item at a time; the result register frees the sequencer, so a result
//  stalled downstream only holds the block in its last step.
// ----------------------------------------------------------------------------
module motor_position_pid (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    output logic                                        o_in_stall,
    input  logic signed [mpp_pkg::POSITION_WIDTH-1:0]   i_measured_position,
    input  logic signed [mpp_pkg::POSITION_WIDTH-1:0]   i_target_position,
    input  logic [19:0]                                 i_elapsed_us,
    output logic                                        o_out_valid,
    input  logic                                        i_out_stall,
    output logic [7:0]                                  o_duty,
    output logic                                        o_pin_a_level,
    output logic                                        o_pin_b_level,
    input  logic                                        i_cfg_wr_en,
    input  logic [1:0]                                  i_cfg_index,
    input  logic [31:0]                                 i_cfg_data
);
    import mpp_pkg::*;

    localparam int DIFF_W = (POSITION_WIDTH + 1 > 33) ? POSITION_WIDTH + 1 : 33;

    // register indexes
    localparam logic [1:0] REG_KP    = 2'd0;
    localparam logic [1:0] REG_KD    = 2'd1;
    localparam logic [1:0] REG_KI    = 2'd2;
    localparam logic [1:0] REG_LIMIT = 2'd3;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ERR  = 4'd1;
    localparam logic [3:0] S_MDIF = 4'd2;
    localparam logic [3:0] S_DRLD = 4'd3;
    localparam logic [3:0] S_DRAT = 4'd4;
    localparam logic [3:0] S_MEDT = 4'd5;
    localparam logic [3:0] S_MKP  = 4'd6;
    localparam logic [3:0] S_MKD  = 4'd7;
    localparam logic [3:0] S_MKIL = 4'd8;
    localparam logic [3:0] S_MKIH = 4'd9;
    localparam logic [3:0] S_IPH  = 4'd10;
    localparam logic [3:0] S_DILD = 4'd11;
    localparam logic [3:0] S_DINT = 4'd12;
    localparam logic [3:0] S_OUT  = 4'd13;

    localparam logic signed [31:0] ERR_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] ERR_MIN = -32'sh8000_0000;
    localparam logic [RATE_MAG_W-1:0] RATE_POS_LIM = RATE_MAG_W'(32'h7FFF_FFFF);
    localparam logic [RATE_MAG_W-1:0] RATE_NEG_LIM = RATE_MAG_W'(32'h8000_0000);
    localparam logic signed [63:0] ES_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] ES_MIN = {1'b1, {63{1'b0}}};

    // control state
    logic [3:0]               r_state;
    logic                     r_out_valid;
    logic signed [31:0]       r_kp, r_kd, r_ki;
    logic [7:0]               r_limit;
    logic signed [31:0]       r_prev;
    logic signed [63:0]       r_esum;

    // datapath
    logic signed [POSITION_WIDTH-1:0] r_pos, r_tgt;
    logic [DEN_W-1:0]         r_dt;
    logic signed [31:0]       r_err;
    logic signed [65:0]       r_prod;
    logic signed [31:0]       r_rate;
    logic signed [DIV_W-1:0]  r_acc;
    logic signed [DIV_W-1:0]  r_ip;
    logic                     r_rneg, r_ineg;
    logic [7:0]               r_duty;
    logic                     r_pin_a;

    logic signed [DIFF_W-1:0] w_diff;
    logic signed [31:0]       w_err;
    logic signed [32:0]       w_ma, w_mb;
    logic [65:0]              w_pmag;
    logic [RATE_MAG_W-1:0]    w_rq;
    logic signed [31:0]       w_rate;
    logic signed [64:0]       w_es_sum;
    logic signed [63:0]       w_es;
    logic [DIV_W-1:0]         w_ipmag;
    logic [DIV_W-1:0]         w_quot;
    logic [DIV_W-1:0]         w_iq;
    logic [DIV_W-1:0]         w_amag;
    logic [DIV_W-25:0]        w_u;
    logic [7:0]               w_duty;
    logic                     w_u_zero;
    logic                     w_load_out;
    logic                     w_div_done;
    t_div_ctl                 w_div;

    // shared divider
    mpp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // saturated position error
    always_comb begin
        w_diff = DIFF_W'(r_pos) - DIFF_W'(r_tgt);
        if (w_diff > DIFF_W'(ERR_MAX))
            w_err = ERR_MAX;
        else if (w_diff < DIFF_W'(ERR_MIN))
            w_err = ERR_MIN;
        else
            w_err = 32'(w_diff);
    end

    // shared multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            S_MDIF: begin
                w_ma = 33'(r_err) - 33'(r_prev);
                w_mb = 33'(MICROS_PER_SEC);
            end
            S_MEDT: begin
                w_ma = 33'(r_err);
                w_mb = 33'(r_dt);
            end
            S_MKP: begin
                w_ma = 33'(r_kp);
                w_mb = 33'(r_err);
            end
            S_MKD: begin
                w_ma = 33'(r_kd);
                w_mb = 33'(r_rate);
            end
            S_MKIL: begin
                w_ma = 33'(r_ki);
                w_mb = {1'b0, r_esum[31:0]};
            end
            S_MKIH: begin
                w_ma = 33'(r_ki);
                w_mb = 33'($signed(r_esum[63:32]));
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // rate: sign and saturation of the divider quotient
    always_comb begin
        w_pmag = r_prod[65] ? 66'(-r_prod) : 66'(r_prod);
        w_rq   = w_quot[RATE_MAG_W-1:0];
        if (r_rneg)
            w_rate = (w_rq > RATE_NEG_LIM) ? ERR_MIN : -$signed(w_rq[31:0]);
        else
            w_rate = (w_rq > RATE_POS_LIM) ? ERR_MAX : $signed(w_rq[31:0]);
    end

    // integral update, saturated to 64 bits
    always_comb begin
        w_es_sum = 65'(r_esum) + 65'(r_prod);
        if (w_es_sum[64] != w_es_sum[63])
            w_es = w_es_sum[64] ? ES_MIN : ES_MAX;
        else
            w_es = w_es_sum[63:0];
    end

    // integral term magnitude and signed quotient
    assign w_ipmag = r_ip[DIV_W-1] ? DIV_W'(-r_ip) : DIV_W'(r_ip);
    assign w_iq    = r_ineg ? (~w_quot + DIV_W'(1)) : w_quot;

    // drive magnitude, truncated toward zero, and clamp
    always_comb begin
        w_amag   = r_acc[DIV_W-1] ? DIV_W'(-r_acc) : DIV_W'(r_acc);
        w_u      = w_amag[DIV_W-1:24];
        w_u_zero = (w_u == '0);
        if ((|w_u[DIV_W-25:8]) || (w_u[7:0] > r_limit))
            w_duty = r_limit;
        else
            w_duty = w_u[7:0];
    end

    assign w_load_out = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    // divider requests
    always_comb begin
        w_div.start    = (r_state == S_DRLD) || (r_state == S_DILD);
        w_div.steps    = (r_state == S_DRLD) ? RATE_STEPS : INT_STEPS;
        w_div.dividend = (r_state == S_DRLD)
                       ? {w_pmag[RATE_MAG_W-1:0], {(DIV_W-RATE_MAG_W){1'b0}}}
                       : w_ipmag;
        w_div.divisor  = (r_state == S_DRLD) ? r_dt : MICROS_PER_SEC;
    end

    // sequencer, configuration and loop state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_kp        <= '0;
            r_kd        <= '0;
            r_ki        <= '0;
            r_limit     <= 8'd50;
            r_prev      <= '0;
            r_esum      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_KP:    r_kp    <= $signed(i_cfg_data);
                    REG_KD:    r_kd    <= $signed(i_cfg_data);
                    REG_KI:    r_ki    <= $signed(i_cfg_data);
                    REG_LIMIT: r_limit <= i_cfg_data[7:0];
                endcase
            end

            if (w_load_out)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: if (i_in_valid) r_state <= S_ERR;
                S_ERR:  r_state <= S_MDIF;
                S_MDIF: begin
                    r_prev  <= r_err;
                    r_state <= S_DRLD;
                end
                S_DRLD: r_state <= S_DRAT;
                S_DRAT: if (w_div_done) r_state <= S_MEDT;
                S_MEDT: r_state <= S_MKP;
                S_MKP: begin
                    r_esum  <= w_es;
                    r_state <= S_MKD;
                end
                S_MKD:  r_state <= S_MKIL;
                S_MKIL: r_state <= S_MKIH;
                S_MKIH: r_state <= S_IPH;
                S_IPH:  r_state <= S_DILD;
                S_DILD: r_state <= S_DINT;
                S_DINT: if (w_div_done) r_state <= S_OUT;
                S_OUT:  if (w_load_out) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 66'(w_ma) * 66'(w_mb);
        if (r_state == S_IDLE && i_in_valid) begin
            r_pos <= i_measured_position;
            r_tgt <= i_target_position;
            r_dt  <= (i_elapsed_us == '0) ? DEN_W'(1) : i_elapsed_us;
        end
        if (r_state == S_ERR)
            r_err <= w_err;
        if (r_state == S_DRLD)
            r_rneg <= r_prod[65];
        if (r_state == S_DRAT && w_div_done)
            r_rate <= w_rate;
        if (r_state == S_MKD)
            r_acc <= DIV_W'(r_prod);
        if (r_state == S_MKIL)
            r_acc <= r_acc + DIV_W'(r_prod);
        if (r_state == S_MKIH)
            r_ip <= DIV_W'(r_prod);
        if (r_state == S_IPH)
            r_ip <= r_ip + $signed({r_prod[63:0], 32'b0});
        if (r_state == S_DILD)
            r_ineg <= r_ip[DIV_W-1];
        if (r_state == S_DINT && w_div_done)
            r_acc <= r_acc + $signed(w_iq);
        if (w_load_out) begin
            r_duty  <= w_duty;
            r_pin_a <= r_acc[DIV_W-1] && !w_u_zero;
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_duty        = r_duty;
    assign o_pin_a_level = r_pin_a;
    assign o_pin_b_level = !r_pin_a;

endmodule

/* hdl/mpp_checker.sv */
// ----------------------------------------------------------------------------
// mpp_checker
// Port-level checks for the motor position PID controller, bound to the
// top level.
// ----------------------------------------------------------------------------
module mpp_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       o_in_stall,
    input  logic       o_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] o_duty,
    input  logic       o_pin_a_level,
    input  logic       o_pin_b_level
);

    // bridge levels never both high or both low on a result
    a_pins_opposite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pin_a_level != o_pin_b_level))
        else $error("bridge levels not complementary");

    // an accepted item keeps the block busy in the next cycle
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again right after a transfer");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_duty) && $stable(o_pin_a_level)))
        else $error("stalled result changed");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind motor_position_pid mpp_checker u_mpp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_duty        (o_duty),
    .o_pin_a_level (o_pin_a_level),
    .o_pin_b_level (o_pin_b_level)
);

/* tb/motor_position_pid_check.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_position_pid_check
// Watches the input, result and register ports of the PID controller, keeps
// its own copy of the gains, the previous error and the error integral, works
// out the duty and bridge levels for every accepted input transfer and
// compares each result transfer against the oldest one still waiting.
// ----------------------------------------------------------------------------
module motor_position_pid_check (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_in_valid,
    input  logic                                        i_in_stall,
    input  logic signed [mpp_pkg::POSITION_WIDTH-1:0]   i_measured_position,
    input  logic signed [mpp_pkg::POSITION_WIDTH-1:0]   i_target_position,
    input  logic [19:0]                                 i_elapsed_us,
    input  logic                                        i_out_valid,
    input  logic                                        i_out_stall,
    input  logic [7:0]                                  i_duty,
    input  logic                                        i_pin_a_level,
    input  logic                                        i_pin_b_level,
    input  logic                                        i_cfg_wr_en,
    input  logic [1:0]                                  i_cfg_index,
    input  logic [31:0]                                 i_cfg_data,
    output int                                          o_fail_count,
    output int                                          o_results_seen
);

    typedef struct packed {
        logic [7:0] duty;
        logic       pin_a;
        logic       pin_b;
    } t_drive;

    localparam logic [1:0] REG_GAIN_P     = 2'd0;
    localparam logic [1:0] REG_GAIN_D     = 2'd1;
    localparam logic [1:0] REG_GAIN_I     = 2'd2;
    localparam logic [1:0] REG_DUTY_LIMIT = 2'd3;

    localparam logic [7:0]          DUTY_LIMIT_RESET = 8'd50;
    localparam logic signed [127:0] MICROS_PER_SEC   = 128'sd1000000;
    localparam int                  REPORT_LINES     = 100;

    // controller copy: gains, clamp and loop state
    logic signed [31:0] gain_p;
    logic signed [31:0] gain_d;
    logic signed [31:0] gain_i;
    logic [7:0]         duty_limit;
    logic signed [31:0] last_error;
    logic signed [63:0] error_integral;

    t_drive pending_drives[$];
    int     mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic logic signed [31:0] clamp_to_32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (x < -64'sd2147483648)
            return 32'sh8000_0000;
        return x[31:0];
    endfunction

    // one control step: error, rate, integral, Q8.24 drive, clamp and sign
    function automatic t_drive compute_drive(
        input logic signed [mpp_pkg::POSITION_WIDTH-1:0] pos,
        input logic signed [mpp_pkg::POSITION_WIDTH-1:0] tgt,
        input logic [19:0]                               elapsed
    );
        logic signed [63:0]  diff;
        logic signed [31:0]  err;
        logic signed [31:0]  rate;
        longint              dt;
        logic signed [63:0]  rate_num;
        logic signed [63:0]  step_area;
        logic signed [64:0]  sum_wide;
        logic signed [127:0] integ_term;
        logic signed [127:0] drive_acc;
        logic signed [127:0] mag;
        logic [127:0]        quot;
        t_drive              res;

        diff = pos - tgt;
        err  = clamp_to_32(diff);
        dt   = (elapsed == 20'd0) ? 64'sd1 : longint'(elapsed);

        rate_num = (longint'(err) - longint'(last_error)) * 64'sd1000000;
        rate     = clamp_to_32(rate_num / dt);

        // integral in count-microseconds, held on the 64-bit rails
        step_area = longint'(err) * dt;
        sum_wide  = error_integral;
        sum_wide  = sum_wide + step_area;
        if (sum_wide[64] != sum_wide[63])
            error_integral = sum_wide[64] ? 64'sh8000_0000_0000_0000
                                          : 64'sh7FFF_FFFF_FFFF_FFFF;
        else
            error_integral = sum_wide[63:0];

        integ_term = gain_i * error_integral;
        integ_term = integ_term / MICROS_PER_SEC;
        drive_acc  = gain_p * err + gain_d * rate + integ_term;

        // truncate toward zero: shift the magnitude
        mag  = (drive_acc < 0) ? -drive_acc : drive_acc;
        quot = mag >> 24;

        res.duty  = (quot > duty_limit) ? duty_limit : quot[7:0];
        res.pin_a = (drive_acc < 0) && (quot != 0);
        res.pin_b = !res.pin_a;

        last_error = err;
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_LINES)
            $display("%0t: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // result check first, then register writes, then the new expectation
    always @(posedge i_clk) begin
        t_drive want;
        t_drive got;

        got = {i_duty, i_pin_a_level, i_pin_b_level};
        if (!i_rst_n) begin
            gain_p         = '0;
            gain_d         = '0;
            gain_i         = '0;
            duty_limit     = DUTY_LIMIT_RESET;
            last_error     = '0;
            error_integral = '0;
            pending_drives.delete();
            o_results_seen <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_results_seen <= o_results_seen + 1;
                if (pending_drives.size() == 0) begin
                    report_mismatch($sformatf("result duty=%0d a=%0b b=%0b with none expected",
                                              got.duty, got.pin_a, got.pin_b));
                end else begin
                    want = pending_drives.pop_front();
                    if (got.duty !== want.duty)
                        report_mismatch($sformatf("duty %0d, expected %0d",
                                                  got.duty, want.duty));
                    if (got.pin_a !== want.pin_a)
                        report_mismatch($sformatf("pin A %0b, expected %0b",
                                                  got.pin_a, want.pin_a));
                    if (got.pin_b !== want.pin_b)
                        report_mismatch($sformatf("pin B %0b, expected %0b",
                                                  got.pin_b, want.pin_b));
                end
            end

            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_GAIN_P:     gain_p = i_cfg_data;
                    REG_GAIN_D:     gain_d = i_cfg_data;
                    REG_GAIN_I:     gain_i = i_cfg_data;
                    REG_DUTY_LIMIT: duty_limit = i_cfg_data[7:0];
                endcase
            end

            if (i_in_valid && !i_in_stall)
                pending_drives.push_back(compute_drive(i_measured_position,
                                                       i_target_position, i_elapsed_us));
        end
    end

endmodule

/* tb/motor_position_pid_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// motor_position_pid_test
// Drives the PID controller with a directed set of edge cases, then random
// control-loop traffic under several gain settings and idle patterns, an
// integral wind-up run, and a long result hold-off; the checker beside the
// block predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module motor_position_pid_test;

    localparam logic [1:0] REG_GAIN_P     = 2'd0;
    localparam logic [1:0] REG_GAIN_D     = 2'd1;
    localparam logic [1:0] REG_GAIN_I     = 2'd2;
    localparam logic [1:0] REG_DUTY_LIMIT = 2'd3;

    localparam int CYCLE_LIMIT  = 4_000_000;
    localparam int HOLD_AT      = 1100;
    localparam int HOLD_CYCLES  = 600;
    localparam int PHASE_ITEMS  = 150;
    localparam int PHASES       = 7;
    localparam int WINDUP_ITEMS = 300;
    localparam int SETTLE_WAIT  = 20;
    localparam int DRAIN_WAIT   = 100;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] Q24_ONE = 32'sh0100_0000;
    localparam logic [19:0]        DT_MAX  = 20'hF_FFFF;

    logic                                        clk         = 1'b0;
    logic                                        rst_n       = 1'b0;
    logic                                        in_valid    = 1'b0;
    logic                                        in_stall;
    logic signed [mpp_pkg::POSITION_WIDTH-1:0]   measured    = '0;
    logic signed [mpp_pkg::POSITION_WIDTH-1:0]   target      = '0;
    logic [19:0]                                 elapsed_us  = '0;
    logic                                        out_valid;
    logic                                        out_stall   = 1'b0;
    logic [7:0]                                  duty;
    logic                                        pin_a_level;
    logic                                        pin_b_level;
    logic                                        cfg_wr_en   = 1'b0;
    logic [1:0]                                  cfg_index   = '0;
    logic [31:0]                                 cfg_data    = '0;

    int                 sent_count     = 0;
    int                 results_seen;
    int                 fail_count;
    int                 send_gap_pct   = 0;
    int                 recv_stall_pct = 0;
    int                 hold_left      = 0;
    bit                 hold_done      = 1'b0;
    int                 cycle_count    = 0;
    logic signed [31:0] setpoint       = '0;

    motor_position_pid dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_measured_position (measured),
        .i_target_position   (target),
        .i_elapsed_us        (elapsed_us),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_duty              (duty),
        .o_pin_a_level       (pin_a_level),
        .o_pin_b_level       (pin_b_level),
        .i_cfg_wr_en         (cfg_wr_en),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    motor_position_pid_check u_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_measured_position (measured),
        .i_target_position   (target),
        .i_elapsed_us        (elapsed_us),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_duty              (duty),
        .i_pin_a_level       (pin_a_level),
        .i_pin_b_level       (pin_b_level),
        .i_cfg_wr_en         (cfg_wr_en),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data),
        .o_fail_count        (fail_count),
        .o_results_seen      (results_seen)
    );

    always #5 clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off so the block backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_count >= HOLD_AT) begin
            out_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    function automatic logic signed [31:0] scaled_rand();
        return $signed($urandom) >>> $urandom_range(31, 0);
    endfunction

    // offer one input item and hold it until the transfer
    task automatic send_item(input logic signed [31:0] pos, input logic signed [31:0] tgt,
                             input logic [19:0] dt);
        while ($urandom_range(99) < send_gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        measured   <= pos;
        target     <= tgt;
        elapsed_us <= dt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    // stop offering and wait until every result has come back
    task automatic settle();
        in_valid <= 1'b0;
        while (results_seen < sent_count)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic configure(input logic signed [31:0] kp, input logic signed [31:0] kd,
                             input logic signed [31:0] ki, input logic [7:0] limit);
        settle();
        write_reg(REG_GAIN_P, kp);
        write_reg(REG_GAIN_D, kd);
        write_reg(REG_GAIN_I, ki);
        write_reg(REG_DUTY_LIMIT, {24'd0, limit});
        cfg_wr_en <= 1'b0;
    endtask

    // mostly a loop tracking a setpoint, some raw noise and odd time steps
    task automatic random_item();
        logic signed [31:0] pos;
        logic signed [31:0] tgt;
        logic [19:0]        dt;
        int                 kind;

        kind = $urandom_range(99);
        if ($urandom_range(19) == 0)
            setpoint = $urandom;
        if (kind < 75) begin
            tgt = setpoint;
            pos = setpoint + ($signed($urandom) >>> $urandom_range(31, 14));
            dt  = ($urandom_range(9) == 0) ? 20'($urandom_range(3))
                                           : 20'($urandom_range(1200, 800));
        end else begin
            pos = $urandom;
            tgt = $urandom;
            dt  = 20'($urandom);
            if (kind >= 95)
                dt = $urandom_range(1) ? 20'd0 : DT_MAX;
        end
        send_item(pos, tgt, dt);
    endtask

    initial begin
        logic [7:0] limit;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 17;
        recv_stall_pct = 69;

        // reset gains: no drive at all
        send_item(5, 0, 100);

        // unit proportional gain, duty limit left at its reset value
        settle();
        write_reg(REG_GAIN_P, Q24_ONE);
        write_reg(REG_GAIN_D, 32'sd1024);
        write_reg(REG_GAIN_I, 32'sd65536);
        cfg_wr_en <= 1'b0;
        send_item(0, 0, 20'd0);
        send_item(30, 0, 1000);
        send_item(-30, 0, 1000);
        send_item(S32_MAX, S32_MIN, 1);
        send_item(S32_MIN, S32_MAX, 1);
        send_item(S32_MIN, S32_MIN, DT_MAX);
        send_item(S32_MAX, S32_MAX, 20'd0);
        send_item(1000, 990, DT_MAX);

        // half gain: drive truncating to zero from both sides, then the clamp
        configure(Q24_ONE >>> 1, 0, 0, 8'd255);
        send_item(1, 0, 500);
        send_item(-1, 0, 500);
        send_item(2, 0, 500);
        send_item(-3, 0, 500);
        send_item(600, 0, 1);
        send_item(-600, 0, 1);

        // extreme gains, zero limit
        configure(S32_MAX, S32_MIN, S32_MAX, 8'd0);
        send_item(100, -100, 1000);
        send_item(-5, 5, DT_MAX);

        configure(S32_MIN, S32_MAX, S32_MIN, 8'd255);
        send_item(S32_MAX, S32_MIN, 1);
        send_item(0, 0, 20'd0);
        send_item(-1, 0, 7);
        send_item(12345, -54321, DT_MAX);

        // random traffic under changing gains and idle patterns
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 3) begin
                send_gap_pct   = 69;
                recv_stall_pct = 17;
            end else if (phase == 5) begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end
            limit = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 8'd255 : 8'd0)
                                             : 8'($urandom_range(255));
            configure(scaled_rand(), scaled_rand(), scaled_rand(), limit);
            repeat (PHASE_ITEMS) random_item();
        end

        // integral wind-up toward the positive rail, then pull it back
        configure(0, 0, 1, 8'd255);
        repeat (WINDUP_ITEMS)
            send_item(S32_MAX - $urandom_range(255), S32_MIN + $urandom_range(255),
                      DT_MAX - 20'($urandom_range(15)));
        repeat (40)
            send_item(S32_MIN + $urandom_range(255), S32_MAX - $urandom_range(255),
                      20'($urandom_range(DT_MAX)));

        settle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && results_seen == sent_count)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
